FILE: design/rc4_stream_cipher_defines.svh
// Assertion helpers for the RC4 block.
// Each macro expects clk and arst_n in scope.
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define RC4_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rc4_pkg.sv
`default_nettype none

package rc4_pkg;

	localparam int TABLE_SIZE    = 256;
	localparam int MAX_KEY_BYTES = 256;

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int KCNT_W = $clog2(MAX_KEY_BYTES + 1);

	typedef logic [7:0]        byte_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [KEY_AW-1:0] kaddr_t;
	typedef logic [KCNT_W-1:0] kcnt_t;

	// Item kind codes
	typedef enum logic {
		CMD_KEY  = 1'b0,
		CMD_DATA = 1'b1
	} cmd_t;

	// Request to the permutation RAM
	typedef struct packed {
		logic  we;
		idx_t  waddr;
		byte_t wdata;
		idx_t  raddr;
	} perm_req_t;

	// Request to the key RAM
	typedef struct packed {
		logic   we;
		kaddr_t waddr;
		byte_t  wdata;
		kaddr_t raddr;
	} key_req_t;

endpackage

`default_nettype wire

FILE: design/rc4_item_if.sv
`default_nettype none

interface rc4_item_if;
	import rc4_pkg::*;

	logic  valid;
	logic  ready;
	logic  cmd;
	byte_t byte_value;
	logic  key_last;

	modport source (output valid, output cmd, output byte_value, output key_last, input ready);
	modport sink (input valid, input cmd, input byte_value, input key_last, output ready);

endinterface

`default_nettype wire

FILE: design/rc4_result_if.sv
`default_nettype none

interface rc4_result_if;
	import rc4_pkg::*;

	logic  valid;
	logic  ready;
	byte_t cipher_byte;

	modport source (output valid, output cipher_byte, input ready);
	modport sink (input valid, input cipher_byte, output ready);

endinterface

`default_nettype wire

FILE: design/rc4_ram.sv
`default_nettype none

module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, read one entry; a read at the written address returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/rc4_seq.sv
`default_nettype none

`include "rc4_stream_cipher_defines.svh"

module rc4_seq (
	input  logic               clk,
	input  logic               arst_n,
	rc4_item_if.sink           item,
	rc4_result_if.source       result,
	output rc4_pkg::perm_req_t perm_req,
	input  rc4_pkg::byte_t     perm_rdata,
	output rc4_pkg::key_req_t  key_req,
	input  rc4_pkg::byte_t     key_rdata
);
	import rc4_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_KS_RD,
		ST_KS_SUM,
		ST_KS_WRN,
		ST_KS_WRA,
		ST_D2,
		ST_D3,
		ST_D4
	} state_t;

	localparam idx_t  LAST_IDX = idx_t'(TABLE_SIZE - 1);
	localparam kcnt_t KEY_MAX  = kcnt_t'(MAX_KEY_BYTES);

	state_t state_q;
	kcnt_t  key_count_q;
	kcnt_t  klen_q;
	kaddr_t kidx_q;
	idx_t   idx_i_q;
	idx_t   idx_j_q;
	idx_t   n_q;
	idx_t   acc_q;
	idx_t   t_q;
	byte_t  hold_q;
	byte_t  sj_q;
	byte_t  val_q;
	logic   keyed_q;
	logic   out_valid_q;
	byte_t  cipher_byte_q;

	logic  item_acc;
	logic  key_room;
	logic  kidx_wrap;
	idx_t  op_a;
	idx_t  op_b;
	idx_t  op_c;
	idx_t  sum;
	byte_t ks;

	assign item_acc  = item.valid && item.ready;
	assign key_room  = key_count_q < KEY_MAX;
	assign kidx_wrap = (kcnt_t'(kidx_q) + kcnt_t'(1)) == klen_q;

	assign item.ready   = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.cipher_byte = cipher_byte_q;

	// Pick operands for the shared byte adder
	always_comb begin
		op_a = idx_i_q;
		op_b = idx_t'(1);
		op_c = '0;
		case (state_q)
			ST_KS_SUM: begin
				op_a = acc_q;
				op_b = perm_rdata;
				op_c = key_rdata;
			end
			ST_D2: begin
				op_a = idx_j_q;
				op_b = perm_rdata;
			end
			ST_D3: begin
				op_a = hold_q;
				op_b = perm_rdata;
			end
			default: begin
				op_a = idx_i_q;
				op_b = idx_t'(1);
			end
		endcase
	end

	assign sum = op_a + op_b + op_c;

	// Keystream byte, forwarding the swapped entries the RAM read missed
	always_comb begin
		if (t_q == idx_j_q) begin
			ks = hold_q;
		end else if (t_q == idx_i_q) begin
			ks = sj_q;
		end else begin
			ks = perm_rdata;
		end
	end

	// Drive the permutation RAM
	always_comb begin
		perm_req.we    = 1'b0;
		perm_req.waddr = n_q;
		perm_req.wdata = n_q;
		perm_req.raddr = t_q;
		case (state_q)
			ST_IDLE: begin
				perm_req.raddr = sum;
			end
			ST_FILL: begin
				perm_req.we = 1'b1;
			end
			ST_KS_RD: begin
				perm_req.raddr = n_q;
			end
			ST_KS_SUM: begin
				perm_req.raddr = sum;
			end
			ST_KS_WRN: begin
				perm_req.we    = 1'b1;
				perm_req.wdata = perm_rdata;
			end
			ST_KS_WRA: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = acc_q;
				perm_req.wdata = hold_q;
			end
			ST_D2: begin
				perm_req.raddr = sum;
			end
			ST_D3: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = idx_i_q;
				perm_req.wdata = perm_rdata;
				perm_req.raddr = sum;
			end
			ST_D4: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = idx_j_q;
				perm_req.wdata = hold_q;
			end
			default: begin
				perm_req.we = 1'b0;
			end
		endcase
	end

	// Drive the key RAM: store key bytes on request, read during the schedule
	assign key_req.we    = item_acc && (item.cmd == CMD_KEY) && key_room;
	assign key_req.waddr = key_count_q[KEY_AW-1:0];
	assign key_req.wdata = item.byte_value;
	assign key_req.raddr = kidx_q;

	// Sequencer state, indices and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			key_count_q   <= '0;
			klen_q        <= '0;
			kidx_q        <= '0;
			idx_i_q       <= '0;
			idx_j_q       <= '0;
			n_q           <= '0;
			acc_q         <= '0;
			t_q           <= '0;
			hold_q        <= '0;
			sj_q          <= '0;
			val_q         <= '0;
			keyed_q       <= 1'b0;
			out_valid_q   <= 1'b0;
			cipher_byte_q <= '0;
		end else begin
			// drop the result once taken; the output step refills it itself
			if (out_valid_q && result.ready && (state_q != ST_D4)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (item.cmd == CMD_KEY) begin
							if (item.key_last) begin
								klen_q      <= key_room ? key_count_q + kcnt_t'(1) : KEY_MAX;
								key_count_q <= '0;
								n_q         <= '0;
								state_q     <= ST_FILL;
							end else if (key_room) begin
								key_count_q <= key_count_q + kcnt_t'(1);
							end
						end else if (keyed_q) begin
							idx_i_q <= sum;
							val_q   <= item.byte_value;
							state_q <= ST_D2;
						end
					end
				end
				ST_FILL: begin
					n_q <= n_q + idx_t'(1);
					if (n_q == LAST_IDX) begin
						acc_q   <= '0;
						kidx_q  <= '0;
						state_q <= ST_KS_RD;
					end
				end
				ST_KS_RD: begin
					state_q <= ST_KS_SUM;
				end
				ST_KS_SUM: begin
					hold_q  <= perm_rdata;
					acc_q   <= sum;
					state_q <= ST_KS_WRN;
				end
				ST_KS_WRN: begin
					state_q <= ST_KS_WRA;
				end
				ST_KS_WRA: begin
					n_q    <= n_q + idx_t'(1);
					kidx_q <= kidx_wrap ? '0 : kidx_q + kaddr_t'(1);
					if (n_q == LAST_IDX) begin
						idx_i_q <= '0;
						idx_j_q <= '0;
						keyed_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_KS_RD;
					end
				end
				ST_D2: begin
					hold_q  <= perm_rdata;
					idx_j_q <= sum;
					state_q <= ST_D3;
				end
				ST_D3: begin
					sj_q    <= perm_rdata;
					t_q     <= sum;
					state_q <= ST_D4;
				end
				ST_D4: begin
					// hold here until the output register is free
					if (!out_valid_q || result.ready) begin
						out_valid_q   <= 1'b1;
						cipher_byte_q <= val_q ^ ks;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RC4_ASSERT_NEXT(a_result_from_d4, (state_q != ST_D4 && !out_valid_q), !out_valid_q,
		"result raised outside the output step")
	`RC4_ASSERT_NEXT(a_fill_to_rounds, (state_q == ST_FILL && n_q == LAST_IDX),
		(state_q == ST_KS_RD && n_q == '0), "table fill did not hand over to the rounds")
	`RC4_ASSERT_NEXT(a_sched_done, (state_q == ST_KS_WRA && n_q == LAST_IDX),
		(keyed_q && idx_i_q == '0 && idx_j_q == '0), "schedule end did not clear indices")
	`RC4_ASSERT_NEXT(a_unkeyed_drop, (item_acc && item.cmd == CMD_DATA && !keyed_q),
		(state_q == ST_IDLE), "unkeyed data byte was processed")
	`RC4_ASSERT_NOW(a_kidx_range, (state_q == ST_KS_RD || state_q == ST_KS_SUM),
		(kcnt_t'(kidx_q) < klen_q), "key index past key length")

endmodule

`default_nettype wire

FILE: design/rc4_stream_cipher.sv
// RC4 stream cipher. Key bytes (cmd 0) are stored one per request, up to 256; further key
// bytes are ignored. A key byte with key_last set runs the key schedule: a table fill of
// 256 entries plus 256 rounds of read, sum and two writes, in which no request is taken.
// Each data byte (cmd 1) then passes through accept plus three steps and yields one
// cipher_byte; no new request is taken until it is done. The steps are set by the single
// read port of the permutation RAM, which serves the three dependent reads of a byte.
// Data bytes sent before the first schedule are dropped without a result. A finished
// result waits in an output register while the next request is accepted.
`default_nettype none

module rc4_stream_cipher (
	input  logic         clk,
	input  logic         arst_n,
	rc4_item_if.sink     item,
	rc4_result_if.source result
);
	import rc4_pkg::*;

	perm_req_t perm_req;
	key_req_t  key_req;
	byte_t     perm_rdata;
	byte_t     key_rdata;

	// Permutation table
	rc4_ram #(
		.WIDTH (8),
		.DEPTH (TABLE_SIZE)
	) u_perm_ram (
		.clk   (clk),
		.we    (perm_req.we),
		.waddr (perm_req.waddr),
		.wdata (perm_req.wdata),
		.raddr (perm_req.raddr),
		.rdata (perm_rdata)
	);

	// Key store
	rc4_ram #(
		.WIDTH (8),
		.DEPTH (MAX_KEY_BYTES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_req.we),
		.waddr (key_req.waddr),
		.wdata (key_req.wdata),
		.raddr (key_req.raddr),
		.rdata (key_rdata)
	);

	// Sequencer with the shared byte adder
	rc4_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.perm_req   (perm_req),
		.perm_rdata (perm_rdata),
		.key_req    (key_req),
		.key_rdata  (key_rdata)
	);

endmodule

`default_nettype wire

FILE: verif/rc4_stream_cipher_test.sv
`default_nettype none

module rc4_stream_cipher_test;
	import rc4_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 1500;
	localparam int RANDOM_ITEMS = 530;

	typedef struct {
		cmd_t  kind;
		byte_t value;
		logic  last;
	} cipher_req_t;

	logic clk;
	logic arst_n;

	rc4_item_if   item_ch ();
	rc4_result_if result_ch ();

	rc4_stream_cipher uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Pending requests and the cipher_byte values they should produce
	cipher_req_t pending_reqs[$];
	byte_t       expected_bytes[$];

	// Private copy of the cipher state
	byte_t perm_mem [TABLE_SIZE];
	byte_t key_mem [MAX_KEY_BYTES];
	int    key_len;
	idx_t  ix_i;
	idx_t  ix_j;
	bit    keyed;

	int          total_reqs;
	int          reqs_taken;
	int          fail_count;
	int unsigned cycle_count;
	bit          req_taken;
	int          phase;
	byte_t       want_byte;

	// Advance the cipher state for one accepted request and record any output
	task automatic cipher_predict(input cmd_t kind, input byte_t value, input logic last);
		idx_t  acc;
		idx_t  ks_idx;
		byte_t tmp;
		int    len;
		if (kind == CMD_KEY) begin
			if (key_len < MAX_KEY_BYTES) begin
				key_mem[key_len] = value;
				key_len++;
			end
			if (last) begin
				len = (key_len == 0) ? MAX_KEY_BYTES : key_len;
				for (int n = 0; n < TABLE_SIZE; n++)
					perm_mem[n] = byte_t'(n);
				acc = '0;
				for (int n = 0; n < TABLE_SIZE; n++) begin
					acc = acc + perm_mem[n] + key_mem[n % len];
					tmp = perm_mem[n];
					perm_mem[n] = perm_mem[acc];
					perm_mem[acc] = tmp;
				end
				key_len = 0;
				ix_i = '0;
				ix_j = '0;
				keyed = 1'b1;
			end
		end else if (keyed) begin
			ix_i = ix_i + 1'b1;
			ix_j = ix_j + perm_mem[ix_i];
			tmp = perm_mem[ix_i];
			perm_mem[ix_i] = perm_mem[ix_j];
			perm_mem[ix_j] = tmp;
			ks_idx = perm_mem[ix_i] + perm_mem[ix_j];
			expected_bytes.push_back(value ^ perm_mem[ks_idx]);
		end
	endtask

	task automatic queue_request(input cmd_t kind, input byte_t value, input logic last);
		cipher_req_t req;
		req.kind = kind;
		req.value = value;
		req.last = last;
		pending_reqs.push_back(req);
	endtask

	// Pick the idle pattern from how far the stimulus has gone
	always_comb begin
		phase = (total_reqs == 0) ? 0 : (reqs_taken * 4) / total_reqs;
		if (phase > 3)
			phase = 3;
	end

	// Clock, reset and start values of all inputs
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_KEY;
		item_ch.byte_value = '0;
		item_ch.key_last = 1'b0;
		result_ch.ready = 1'b0;
		forever #10 clk = ~clk;
	end

	// Drive requests at the falling edge; hold a request until it is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			result_ch.ready <= 1'b0;
		end else begin
			if (item_ch.valid && !req_taken) begin
				// hold the current request
			end else if (pending_reqs.size() > 0 &&
					!((phase == 1 && $urandom_range(0, 99) < 45) ||
					(phase == 3 && $urandom_range(0, 99) < 23))) begin
				item_ch.valid <= 1'b1;
				item_ch.cmd <= pending_reqs[0].kind;
				item_ch.byte_value <= pending_reqs[0].value;
				item_ch.key_last <= pending_reqs[0].last;
				void'(pending_reqs.pop_front());
			end else begin
				item_ch.valid <= 1'b0;
			end
			result_ch.ready <= !((phase == 2 && $urandom_range(0, 99) < 45) ||
				(phase == 3 && $urandom_range(0, 99) < 23));
		end
	end

	// Sample both channels at the rising edge; predict and check
	always @(posedge clk) begin
		req_taken = 1'b0;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			cipher_predict(cmd_t'(item_ch.cmd), item_ch.byte_value, item_ch.key_last);
			req_taken = 1'b1;
			reqs_taken++;
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: cipher_byte expected none, got %02h", $time,
					result_ch.cipher_byte);
				fail_count++;
			end else begin
				want_byte = expected_bytes.pop_front();
				if (result_ch.cipher_byte !== want_byte) begin
					$display("%0t: cipher_byte expected %02h, got %02h", $time, want_byte,
						result_ch.cipher_byte);
					fail_count++;
				end
			end
		end
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d requests taken, %0d results outstanding", $time,
				reqs_taken, expected_bytes.size());
			$display("rc4_stream_cipher verification failed");
			$finish;
		end
	end

	// Build the stimulus, release reset and wait for the run to drain
	initial begin
		int seg;
		int klen;
		int dlen;
		int random_count;
		key_len = 0;
		ix_i = '0;
		ix_j = '0;
		keyed = 1'b0;
		total_reqs = 0;
		reqs_taken = 0;
		fail_count = 0;
		cycle_count = 0;
		req_taken = 1'b0;

		// data before any key, one of them marked last
		queue_request(CMD_DATA, 8'h00, 1'b0);
		queue_request(CMD_DATA, 8'hFF, 1'b1);
		// one-byte key
		queue_request(CMD_KEY, 8'hFF, 1'b1);
		queue_request(CMD_DATA, 8'h00, 1'b0);
		queue_request(CMD_DATA, 8'hFF, 1'b0);
		queue_request(CMD_DATA, 8'h5A, 1'b1);
		queue_request(CMD_DATA, 8'hA5, 1'b0);
		// start a new key; the old stream keeps running until its last byte
		queue_request(CMD_KEY, 8'h00, 1'b0);
		queue_request(CMD_KEY, 8'h80, 1'b0);
		queue_request(CMD_DATA, 8'h3C, 1'b0);
		queue_request(CMD_DATA, 8'hC3, 1'b0);
		queue_request(CMD_KEY, 8'h7F, 1'b1);
		queue_request(CMD_DATA, 8'h01, 1'b0);
		queue_request(CMD_DATA, 8'h80, 1'b1);
		queue_request(CMD_DATA, 8'hFE, 1'b0);
		queue_request(CMD_DATA, 8'h55, 1'b0);

		// Random keys and streams; one full-size key and one overrun key
		seg = 0;
		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			if (seg == 2)
				klen = MAX_KEY_BYTES;
			else if (seg == 3)
				klen = MAX_KEY_BYTES + $urandom_range(1, 4);
			else if ($urandom_range(0, 3) == 0)
				klen = $urandom_range(9, 32);
			else
				klen = $urandom_range(1, 8);
			for (int k = 0; k < klen; k++) begin
				queue_request(CMD_KEY, byte_t'($urandom_range(0, 255)), k == klen - 1);
				if (k < MAX_KEY_BYTES)
					random_count++;
			end
			dlen = $urandom_range(4, 30);
			for (int k = 0; k < dlen; k++) begin
				// drop in a stray key byte now and then
				if ($urandom_range(0, 99) < 3) begin
					queue_request(CMD_KEY, byte_t'($urandom_range(0, 255)), 1'b0);
					random_count++;
				end
				queue_request(CMD_DATA, byte_t'($urandom_range(0, 255)),
					$urandom_range(0, 4) == 0);
				random_count++;
			end
			seg++;
		end
		total_reqs = pending_reqs.size();

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		while (reqs_taken < total_reqs)
			@(posedge clk);
		while (expected_bytes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_bytes.size() > 0) begin
			$display("%0t: %0d cipher_byte results never arrived", $time,
				expected_bytes.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("rc4_stream_cipher verification clean");
		end else begin
			$display("rc4_stream_cipher verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
